[hdl/pwmt_pkg.sv]
// Shared types and constants for the basic PWM timer.
// Used by pwmt_core, pwmt_out_buf and basic_pwm_timer; depends on nothing.
package pwmt_pkg;

  localparam int CHANNELS   = 6;
  localparam int COUNT_BITS = 16;
  localparam int VALUE_BITS = 16;
  localparam int OP_BITS    = 3;
  localparam int CHAN_BITS  = 3;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;

  // Item opcodes.
  localparam logic [OP_BITS-1:0] OP_TICK       = 3'd0;
  localparam logic [OP_BITS-1:0] OP_WR_COMPARE = 3'd1;
  localparam logic [OP_BITS-1:0] OP_WR_ENABLE  = 3'd2;
  localparam logic [OP_BITS-1:0] OP_WR_RUN     = 3'd3;
  localparam logic [OP_BITS-1:0] OP_CLR_FLAG   = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_MODE = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RESOLUTION  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_INVERT_MASK = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IRQ_ENABLE  = 2'd3;

  typedef struct packed {
    logic                  center_mode;
    logic [COUNT_BITS-1:0] resolution;
    logic [CHANNELS-1:0]   invert_mask;
    logic                  period_irq_enable;
  } cfg_t;

  typedef struct packed {
    logic [CHANNELS-1:0]   pwm_out;
    logic [COUNT_BITS-1:0] count_now;
    logic                  period_flag;
    logic                  irq;
  } result_t;

endpackage

[hdl/pwmt_core.sv]
// Timer state and the per-item update: counter, compare registers, levels.
// Depends on pwmt_pkg.
module pwmt_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              fire_i,
  input  logic [pwmt_pkg::OP_BITS-1:0]      opcode_i,
  input  logic [pwmt_pkg::CHAN_BITS-1:0]    chan_i,
  input  logic [pwmt_pkg::VALUE_BITS-1:0]   value_i,
  input  pwmt_pkg::cfg_t                    cfg_i,
  output pwmt_pkg::result_t                 result_o
);

  localparam int CH = pwmt_pkg::CHANNELS;
  localparam int CB = pwmt_pkg::COUNT_BITS;

  logic [CB-1:0] counter_q, counter_d;
  logic          down_q, down_d;
  logic [CB-1:0] cmp_act_q [CH];
  logic [CB-1:0] cmp_act_d [CH];
  logic [CB-1:0] cmp_buf_q [CH];
  logic [CB-1:0] cmp_buf_d [CH];
  logic [CH-1:0] levels_q, levels_d;
  logic [CH-1:0] oen_q, oen_d;
  logic          run_q, run_d;
  logic          flag_q, flag_d;

  logic [CB-1:0] res_eff;
  logic [CB-1:0] top_edge;
  logic [CB-1:0] cnt_next;
  logic          up;
  logic          period_pt;

  always_comb begin
    res_eff  = (cfg_i.resolution < CB'(2)) ? CB'(2) : cfg_i.resolution;
    top_edge = res_eff - CB'(1);

    counter_d = counter_q;
    down_d    = down_q;
    levels_d  = levels_q;
    oen_d     = oen_q;
    run_d     = run_q;
    flag_d    = flag_q;
    cmp_act_d = cmp_act_q;
    cmp_buf_d = cmp_buf_q;
    up        = 1'b1;
    cnt_next  = counter_q;
    period_pt = 1'b0;

    case (opcode_i)
      pwmt_pkg::OP_TICK: begin
        if (run_q) begin
          if (cfg_i.center_mode) begin
            // Turn upward at zero; turn downward once the top is reached.
            up = (!down_q && (counter_q < res_eff)) || (counter_q == '0);
            cnt_next = up ? counter_q + CB'(1) : counter_q - CB'(1);
            if (cnt_next >= res_eff) begin
              down_d = 1'b1;
            end else if (cnt_next == '0) begin
              down_d = 1'b0;
            end else begin
              down_d = !up;
            end
            period_pt = up && (cnt_next == res_eff);
            for (int i = 0; i < CH; i++) begin
              if (cmp_act_q[i] == cnt_next) begin
                levels_d[i] = up;
              end
            end
          end else begin
            cnt_next  = (counter_q >= top_edge) ? '0 : counter_q + CB'(1);
            down_d    = 1'b0;
            period_pt = (cnt_next == top_edge);
            if (cnt_next == '0) begin
              levels_d = '1;
            end
            // A match on the same tick as the wrap still drives the channel low.
            for (int i = 0; i < CH; i++) begin
              if (cmp_act_q[i] == cnt_next) begin
                levels_d[i] = 1'b0;
              end
            end
          end
          counter_d = cnt_next;
          if (period_pt) begin
            cmp_act_d = cmp_buf_q;
            flag_d    = 1'b1;
          end
        end
      end
      pwmt_pkg::OP_WR_COMPARE: begin
        for (int i = 0; i < CH; i++) begin
          if (chan_i == pwmt_pkg::CHAN_BITS'(i)) begin
            cmp_buf_d[i] = value_i[CB-1:0];
          end
        end
      end
      pwmt_pkg::OP_WR_ENABLE: begin
        oen_d = value_i[CH-1:0];
      end
      pwmt_pkg::OP_WR_RUN: begin
        run_d = value_i[0];
        if (value_i[0]) begin
          flag_d = 1'b0;
        end
      end
      pwmt_pkg::OP_CLR_FLAG: begin
        flag_d = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      counter_q <= '0;
      down_q    <= 1'b0;
      levels_q  <= '0;
      oen_q     <= '0;
      run_q     <= 1'b0;
      flag_q    <= 1'b0;
      for (int i = 0; i < CH; i++) begin
        cmp_act_q[i] <= '0;
        cmp_buf_q[i] <= '0;
      end
    end else if (fire_i) begin
      counter_q <= counter_d;
      down_q    <= down_d;
      levels_q  <= levels_d;
      oen_q     <= oen_d;
      run_q     <= run_d;
      flag_q    <= flag_d;
      cmp_act_q <= cmp_act_d;
      cmp_buf_q <= cmp_buf_d;
    end
  end

  // The result reflects the state after this item has been applied.
  always_comb begin
    result_o.pwm_out     = (levels_d ^ cfg_i.invert_mask) & oen_d;
    result_o.count_now   = counter_d;
    result_o.period_flag = flag_d;
    result_o.irq         = flag_d & cfg_i.period_irq_enable;
  end

endmodule

[hdl/pwmt_out_buf.sv]
// Result register with a skid stage so the input side keeps flowing
// while one result waits. Depends on pwmt_pkg.
module pwmt_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_fire_i,
  input  pwmt_pkg::result_t in_data_i,
  output logic              full_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output pwmt_pkg::result_t out_data_o
);

  logic              out_v_q;
  logic              skid_v_q;
  pwmt_pkg::result_t out_q;
  pwmt_pkg::result_t skid_q;
  logic              out_fire;

  assign out_fire    = out_v_q && !out_stall_i;
  assign full_o      = skid_v_q;
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (in_fire_i) begin
      // An item is only taken while the skid stage is empty.
      if (!out_v_q || out_fire) begin
        out_v_q <= 1'b1;
      end else begin
        skid_v_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_v_q  <= skid_v_q;
      skid_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      if (!out_v_q || out_fire) begin
        out_q <= in_data_i;
      end else begin
        skid_q <= in_data_i;
      end
    end else if (out_fire && skid_v_q) begin
      out_q <= skid_q;
    end
  end

endmodule

[hdl/basic_pwm_timer.sv]
// Basic PWM timer: multi-channel PWM generator on one shared counter.
// Input channel: in_valid_i/in_stall_o with opcode_i, chan_i, value_i.
//   Opcodes tick, write compare, write output enables, write run and
//   clear flag. Each accepted item produces exactly one result item.
// Output channel: out_valid_o/out_stall_i with pwm_out_o, count_now_o,
//   period_flag_o and irq_o, all showing the state after the item.
// Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
//   ready is always high. Write only while the block is idle.
// Result path: the result of an accepted item is registered before it is shown.
// Throughput: one item per cycle when not stalled; the whole update is a
//   single pass of logic from the timer state registers to the result register.
// Stalls: a result register plus one skid entry hold results while the
//   receiver stalls; in_stall_o rises only when both are occupied.
// Reset: asynchronous, active low; clears the counter, compare registers,
//   levels, enables and flags, and sets resolution to 65535.
// Depends on pwmt_pkg, pwmt_core and pwmt_out_buf.
module basic_pwm_timer (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [pwmt_pkg::OP_BITS-1:0]        opcode_i,
  input  logic [pwmt_pkg::CHAN_BITS-1:0]      chan_i,
  input  logic [pwmt_pkg::VALUE_BITS-1:0]     value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [pwmt_pkg::CHANNELS-1:0]       pwm_out_o,
  output logic [pwmt_pkg::COUNT_BITS-1:0]     count_now_o,
  output logic                                period_flag_o,
  output logic                                irq_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [pwmt_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [pwmt_pkg::CFG_DATA_BITS-1:0]  cfg_data_i
);

  pwmt_pkg::cfg_t    cfg_q;
  pwmt_pkg::result_t core_res;
  pwmt_pkg::result_t out_res;
  logic              buf_full;
  logic              in_fire;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = buf_full;
  assign in_fire     = in_valid_i && !buf_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.center_mode       <= 1'b0;
      cfg_q.resolution        <= '1;
      cfg_q.invert_mask       <= '0;
      cfg_q.period_irq_enable <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        pwmt_pkg::CFG_CENTER_MODE: cfg_q.center_mode <= cfg_data_i[0];
        pwmt_pkg::CFG_RESOLUTION:
          cfg_q.resolution <= cfg_data_i[pwmt_pkg::COUNT_BITS-1:0];
        pwmt_pkg::CFG_INVERT_MASK:
          cfg_q.invert_mask <= cfg_data_i[pwmt_pkg::CHANNELS-1:0];
        pwmt_pkg::CFG_IRQ_ENABLE: cfg_q.period_irq_enable <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  pwmt_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (in_fire),
    .opcode_i (opcode_i),
    .chan_i   (chan_i),
    .value_i  (value_i),
    .cfg_i    (cfg_q),
    .result_o (core_res)
  );

  pwmt_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_fire_i   (in_fire),
    .in_data_i   (core_res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_res)
  );

  assign pwm_out_o     = out_res.pwm_out;
  assign count_now_o   = out_res.count_now;
  assign period_flag_o = out_res.period_flag;
  assign irq_o         = out_res.irq;

endmodule

[test/tb_basic_pwm_timer.sv]
// Self-checking testbench for basic_pwm_timer: directed and random items with idling and stalls.
// An in-file scoreboard predicts every result; it depends on pwmt_pkg and the RTL only.
`timescale 1ns / 1ps

class pwm_timer_scoreboard;
  bit                                 center_mode;
  bit [pwmt_pkg::COUNT_BITS-1:0]      resolution;
  bit [pwmt_pkg::CHANNELS-1:0]        invert_mask;
  bit                                 irq_enable;
  bit [pwmt_pkg::COUNT_BITS-1:0]      count;
  bit                                 counting_down;
  bit [pwmt_pkg::COUNT_BITS-1:0]      cmp_active [pwmt_pkg::CHANNELS];
  bit [pwmt_pkg::COUNT_BITS-1:0]      cmp_buffer [pwmt_pkg::CHANNELS];
  bit [pwmt_pkg::CHANNELS-1:0]        levels;
  bit [pwmt_pkg::CHANNELS-1:0]        enables;
  bit                                 running;
  bit                                 period_flag;
  pwmt_pkg::result_t                  expected_q [$];
  int                                 errors;

  function new();
    resolution = '1;
    errors     = 0;
  endfunction

  function void write_reg(logic [pwmt_pkg::CFG_IDX_BITS-1:0] idx,
                          logic [pwmt_pkg::CFG_DATA_BITS-1:0] data);
    case (idx)
      pwmt_pkg::CFG_CENTER_MODE: center_mode = data[0];
      pwmt_pkg::CFG_RESOLUTION:  resolution  = data[pwmt_pkg::COUNT_BITS-1:0];
      pwmt_pkg::CFG_INVERT_MASK: invert_mask = data[pwmt_pkg::CHANNELS-1:0];
      pwmt_pkg::CFG_IRQ_ENABLE:  irq_enable  = data[0];
      default: ;
    endcase
  endfunction

  // One counter step. Matches are judged at the new count against the
  // compare values in force before the period point reloads them.
  function void advance();
    int unsigned top;
    int unsigned nxt;
    bit          up;
    bit          at_period;
    int          i;
    top = resolution;
    if (top < 2) top = 2;
    if (center_mode) begin
      if ((!counting_down && count < top) || count == 0) begin
        up  = 1'b1;
        nxt = count + 1;
      end else begin
        up  = 1'b0;
        nxt = count - 1;
      end
      if (nxt >= top) counting_down = 1'b1;
      else if (nxt == 0) counting_down = 1'b0;
      else counting_down = !up;
      at_period = up && nxt == top;
      for (i = 0; i < pwmt_pkg::CHANNELS; i++)
        if (cmp_active[i] == nxt) levels[i] = up;
    end else begin
      nxt = (count >= top - 1) ? 0 : count + 1;
      counting_down = 1'b0;
      at_period = nxt == top - 1;
      if (nxt == 0) levels = '1;
      for (i = 0; i < pwmt_pkg::CHANNELS; i++)
        if (cmp_active[i] == nxt) levels[i] = 1'b0;
    end
    count = nxt[pwmt_pkg::COUNT_BITS-1:0];
    if (at_period) begin
      cmp_active  = cmp_buffer;
      period_flag = 1'b1;
    end
  endfunction

  function void note_item(logic [pwmt_pkg::OP_BITS-1:0] op,
                          logic [pwmt_pkg::CHAN_BITS-1:0] ch,
                          logic [pwmt_pkg::VALUE_BITS-1:0] val);
    pwmt_pkg::result_t res;
    case (op)
      pwmt_pkg::OP_TICK:       if (running) advance();
      pwmt_pkg::OP_WR_COMPARE: if (ch < pwmt_pkg::CHANNELS) cmp_buffer[ch] = val;
      pwmt_pkg::OP_WR_ENABLE:  enables = val[pwmt_pkg::CHANNELS-1:0];
      pwmt_pkg::OP_WR_RUN: begin
        running = val[0];
        if (val[0]) period_flag = 1'b0;
      end
      pwmt_pkg::OP_CLR_FLAG:   period_flag = 1'b0;
      default: ;
    endcase
    res.pwm_out     = (levels ^ invert_mask) & enables;
    res.count_now   = count;
    res.period_flag = period_flag;
    res.irq         = period_flag & irq_enable;
    expected_q.push_back(res);
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  task report(string msg);
    errors++;
    if (errors <= 50) $display("%0t ns: %s", $time, msg);
  endtask

  task check_result(logic [pwmt_pkg::CHANNELS-1:0] pwm, logic [pwmt_pkg::COUNT_BITS-1:0] cnt,
                    logic flag, logic irq_level);
    pwmt_pkg::result_t want;
    if (expected_q.size() == 0) begin
      report("result arrived with no item outstanding");
    end else begin
      want = expected_q.pop_front();
      if (pwm !== want.pwm_out)
        report($sformatf("pwm_out: expected %h, got %h", want.pwm_out, pwm));
      if (cnt !== want.count_now)
        report($sformatf("count_now: expected %0d, got %0d", want.count_now, cnt));
      if (flag !== want.period_flag)
        report($sformatf("period_flag: expected %b, got %b", want.period_flag, flag));
      if (irq_level !== want.irq)
        report($sformatf("irq: expected %b, got %b", want.irq, irq_level));
    end
  endtask
endclass

module tb_basic_pwm_timer;

  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 135;
  localparam logic [pwmt_pkg::OP_BITS-1:0] OP_FIRST_UNUSED = pwmt_pkg::OP_CLR_FLAG + 3'd1;

  logic                               clk_i;
  logic                               rst_ni;
  logic                               in_valid_i;
  logic                               in_stall_o;
  logic [pwmt_pkg::OP_BITS-1:0]       opcode_i;
  logic [pwmt_pkg::CHAN_BITS-1:0]     chan_i;
  logic [pwmt_pkg::VALUE_BITS-1:0]    value_i;
  logic                               out_valid_o;
  logic                               out_stall_i;
  logic [pwmt_pkg::CHANNELS-1:0]      pwm_out_o;
  logic [pwmt_pkg::COUNT_BITS-1:0]    count_now_o;
  logic                               period_flag_o;
  logic                               irq_o;
  logic                               cfg_valid_i;
  logic                               cfg_ready_o;
  logic [pwmt_pkg::CFG_IDX_BITS-1:0]  cfg_index_i;
  logic [pwmt_pkg::CFG_DATA_BITS-1:0] cfg_data_i;

  pwm_timer_scoreboard sb = new();
  int idle_pct;
  int stall_pct;
  int cycles;
  int cur_res;

  basic_pwm_timer DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .opcode_i(opcode_i), .chan_i(chan_i), .value_i(value_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .pwm_out_o(pwm_out_o), .count_now_o(count_now_o),
    .period_flag_o(period_flag_o), .irq_o(irq_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(negedge clk_i) out_stall_i <= ($urandom_range(99) < stall_pct);

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result(pwm_out_o, count_now_o, period_flag_o, irq_o);
    end
  end

  task send_item(input logic [pwmt_pkg::OP_BITS-1:0] op,
                 input logic [pwmt_pkg::CHAN_BITS-1:0] ch,
                 input logic [pwmt_pkg::VALUE_BITS-1:0] val);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    opcode_i   = op;
    chan_i     = ch;
    value_i    = val;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_item(op, ch, val);
  endtask

  task drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task write_reg(input logic [pwmt_pkg::CFG_IDX_BITS-1:0] idx,
                 input logic [pwmt_pkg::CFG_DATA_BITS-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
  endtask

  // Registers are only touched once every outstanding result has come back.
  task configure(input logic [15:0] mode, input logic [15:0] res,
                 input logic [15:0] inv, input logic [15:0] irq_en);
    drain();
    write_reg(pwmt_pkg::CFG_CENTER_MODE, mode);
    write_reg(pwmt_pkg::CFG_RESOLUTION, res);
    write_reg(pwmt_pkg::CFG_INVERT_MASK, inv);
    write_reg(pwmt_pkg::CFG_IRQ_ENABLE, irq_en);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    cur_res = (res < 2) ? 2 : res;
  endtask

  // Mostly short periods so that period points and wraps come often.
  function logic [15:0] pick_resolution();
    case ($urandom_range(9))
      0:       return 16'($urandom_range(1));
      1:       return 16'd2;
      2:       return 16'hFFFF;
      3:       return 16'($urandom);
      4, 5, 6: return 16'($urandom_range(12, 3));
      default: return 16'($urandom_range(80, 13));
    endcase
  endfunction

  task random_item();
    int                              sel;
    logic [pwmt_pkg::OP_BITS-1:0]    op;
    logic [pwmt_pkg::CHAN_BITS-1:0]  ch;
    logic [pwmt_pkg::VALUE_BITS-1:0] val;
    sel = $urandom_range(99);
    ch  = 3'($urandom);
    val = 16'($urandom);
    if (sel < 68) begin
      op = pwmt_pkg::OP_TICK;
    end else if (sel < 82) begin
      op = pwmt_pkg::OP_WR_COMPARE;
      ch = ($urandom_range(9) == 0) ? 3'($urandom_range(7, pwmt_pkg::CHANNELS))
                                    : 3'($urandom_range(pwmt_pkg::CHANNELS - 1));
      if ($urandom_range(4) != 0) val = 16'($urandom_range(cur_res + 1));
    end else if (sel < 88) begin
      op = pwmt_pkg::OP_WR_ENABLE;
    end else if (sel < 93) begin
      op = pwmt_pkg::OP_WR_RUN;
      val[0] = ($urandom_range(5) != 0);
    end else if (sel < 97) begin
      op = pwmt_pkg::OP_CLR_FLAG;
    end else begin
      op = OP_FIRST_UNUSED + 3'($urandom_range(2));
    end
    send_item(op, ch, val);
  endtask

  initial begin
    logic [15:0] mode_data;
    logic [15:0] inv_data;
    int          k;
    int          ph;
    in_valid_i  = 1'b0;
    opcode_i    = pwmt_pkg::OP_TICK;
    chan_i      = '0;
    value_i     = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = pwmt_pkg::CFG_CENTER_MODE;
    cfg_data_i  = '0;
    idle_pct    = 0;
    stall_pct   = 0;
    cur_res     = 65535;
    rst_ni      = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // Edge mode with a four-count period.
    configure(16'd0, 16'd4, 16'd0, 16'd1);
    send_item(pwmt_pkg::OP_TICK, 3'd0, 16'd0);  // stopped timer ignores ticks
    send_item(pwmt_pkg::OP_WR_COMPARE, 3'd0, 16'd0);
    send_item(pwmt_pkg::OP_WR_COMPARE, 3'd1, 16'd2);
    send_item(pwmt_pkg::OP_WR_COMPARE, 3'd5, 16'hFFFF);
    send_item(pwmt_pkg::OP_WR_COMPARE, 3'd6, 16'd1);
    send_item(pwmt_pkg::OP_WR_COMPARE, 3'd7, 16'd1);
    send_item(pwmt_pkg::OP_WR_ENABLE, 3'd0, 16'hFFFF);
    for (k = 0; k < 3; k++) send_item(OP_FIRST_UNUSED + 3'(k), 3'd7, 16'hFFFF);
    send_item(pwmt_pkg::OP_WR_RUN, 3'd0, 16'd1);
    repeat (5) send_item(pwmt_pkg::OP_TICK, 3'd0, 16'd0);
    send_item(pwmt_pkg::OP_CLR_FLAG, 3'd0, 16'd0);
    send_item(pwmt_pkg::OP_WR_RUN, 3'd0, 16'hFFFE);
    send_item(pwmt_pkg::OP_TICK, 3'd0, 16'd0);

    // Center mode with a resolution below the minimum, all outputs inverted.
    configure(16'd1, 16'd0, 16'h3F, 16'd0);
    send_item(pwmt_pkg::OP_WR_RUN, 3'd0, 16'd1);
    repeat (5) send_item(pwmt_pkg::OP_TICK, 3'd0, 16'd0);
    send_item(pwmt_pkg::OP_WR_ENABLE, 3'd0, 16'd0);

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 62; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 62; end
        default: begin idle_pct = 16; stall_pct = 16; end
      endcase
      mode_data    = 16'($urandom);
      mode_data[0] = ph[0];
      inv_data     = (ph == 0) ? 16'h0 : (ph == 1) ? 16'hFFFF : 16'($urandom);
      configure(mode_data, pick_resolution(), inv_data, 16'($urandom));
      send_item(pwmt_pkg::OP_WR_RUN, 3'($urandom), 16'($urandom) | 16'd1);
      repeat (PHASE_ITEMS) random_item();
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
